/* sv/imrb_pkg.sv */
// Package with the shared types and constants of the interrupt and mode register block.
package imrb_pkg;

  localparam int unsigned NUM_SRC = 6;
  localparam int unsigned MODE_W  = 10;
  localparam int unsigned DATA_W  = 32;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [3:0] OFF_MODE    = 4'h0;
  localparam logic [3:0] OFF_VERSION = 4'h4;
  localparam logic [3:0] OFF_PENDING = 4'h8;
  localparam logic [3:0] OFF_MASK    = 4'hC;

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0202_0102;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              accepted;
    logic              changed;
    logic              host_event;
  } res_t;

endpackage

/* sv/interrupt_mode_register_block_top.sv */
// Top level of the interrupt and mode register block with a two-entry result buffer.
// A result word is registered in out_r, or in skid_r and then out_r when the output is stalled.
// One input word per cycle while skid_r is empty, set by the single register update path.
// A second result register lets one more word in while the output is stalled.
// Reset (rst_n low, synchronous) clears mode, mask and pending bits and empties both
// result registers.
module interrupt_mode_register_block_top
  import imrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [2:0]  in_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_accepted,
  output logic        out_changed,
  output logic        out_host_event
);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [NUM_SRC-1:0] mask_r, mask_nxt;
  logic [NUM_SRC-1:0] pend_r, pend_nxt;

  res_t res_c;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;

  logic [11:0]        wd;
  logic [NUM_SRC-1:0] src_oh;
  logic               src_ok;
  logic               off_ok;
  logic               in_fire;

  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;

  assign wd     = in_write_data[11:0];
  assign src_ok = (in_source < 3'(NUM_SRC));
  assign src_oh = NUM_SRC'(1) << in_source;
  assign off_ok = in_reg_offset inside {OFF_MODE, OFF_VERSION, OFF_PENDING, OFF_MASK};

  always_comb begin
    mode_nxt = mode_r;
    mask_nxt = mask_r;
    pend_nxt = pend_r;
    res_c    = '0;
    case (in_action)
      ACT_WRITE: begin
        res_c.accepted = off_ok;
        if (in_reg_offset == OFF_MODE) begin
          mode_nxt[6:0] = wd[6:0];
          if (wd[8]) begin
            mode_nxt[7] = 1'b1;
          end else if (wd[7]) begin
            mode_nxt[7] = 1'b0;
          end
          if (wd[10]) begin
            mode_nxt[8] = 1'b1;
          end else if (wd[9]) begin
            mode_nxt[8] = 1'b0;
          end
          res_c.host_event = wd[11];
        end else if (in_reg_offset == OFF_MASK) begin
          for (int k = 0; k < NUM_SRC; k++) begin
            if (wd[2*k+1]) begin
              mask_nxt[k] = 1'b1;
            end else if (wd[2*k]) begin
              mask_nxt[k] = 1'b0;
            end
          end
        end
      end
      ACT_READ: begin
        res_c.accepted = off_ok;
        case (in_reg_offset)
          OFF_MODE:    res_c.read_data = DATA_W'(mode_r);
          OFF_VERSION: res_c.read_data = VERSION_WORD;
          OFF_PENDING: res_c.read_data = DATA_W'(pend_r);
          OFF_MASK:    res_c.read_data = DATA_W'(mask_r);
          default:     res_c.read_data = '0;
        endcase
      end
      ACT_RAISE: begin
        res_c.accepted = src_ok;
        if (src_ok) begin
          pend_nxt = pend_r | (mask_r & src_oh);
        end
        res_c.changed = (pend_nxt != pend_r);
      end
      default: begin
        res_c.accepted = src_ok;
        if (src_ok) begin
          pend_nxt = pend_r & ~src_oh;
        end
        res_c.changed = (pend_nxt != pend_r);
      end
    endcase
  end

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (in_fire) begin
        out_nxt   = res_c;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_nxt   = res_c;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      mask_r   <= '0;
      pend_r   <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r <= mode_nxt;
        mask_r <= mask_nxt;
        pend_r <= pend_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_read_data  = out_r.read_data;
  assign out_accepted   = out_r.accepted;
  assign out_changed    = out_r.changed;
  assign out_host_event = out_r.host_event;

endmodule

/* sv/imrb_checker.sv */
// Port checker for the interrupt and mode register block and its bind statement.
module imrb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_accepted,
  input logic        out_changed,
  input logic        out_host_event
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word shown right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped while stalled.");

  a_changed_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_changed |-> out_accepted)
    else $error("Pending change reported on a rejected word.");

  a_event_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_host_event |-> out_accepted && !out_changed && out_read_data == 32'd0)
    else $error("Host event on a word that is not a mode write.");

  a_read_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 32'd0 |-> out_accepted && !out_changed)
    else $error("Read data on a word that is not an accepted read.");

endmodule

bind interrupt_mode_register_block_top imrb_checker u_imrb_checker (.*);
